[sv/gdu_pkg.sv]
`timescale 1ns / 1ps
// gdu_pkg: shared types, codes and constants for the genotype dosage unpacker.
// No dependencies.
package gdu_pkg;

  localparam int DEF_MAX_SAMPLES    = 1048576;
  localparam int DEF_FREQ_FRAC_BITS = 16;
  localparam int NUM_SAMPLES_W      = 21;
  localparam int INDEX_W            = 20;
  localparam int FREQ_W             = 16;
  localparam int LANES              = 4;

  // register index (paddr[2])
  localparam logic REG_NUM_SAMPLES   = 1'b0;
  localparam logic REG_ALLOW_MISSING = 1'b1;

  // 2-bit genotype codes
  localparam logic [1:0] CODE_HOM_A = 2'b00;
  localparam logic [1:0] CODE_MISS  = 2'b01;
  localparam logic [1:0] CODE_HET   = 2'b10;
  localparam logic [1:0] CODE_HOM_B = 2'b11;

  typedef struct packed {
    logic [1:0] dos;
    logic       miss;
  } lane_t;

  typedef lane_t [LANES-1:0] lane_vec_t;

  // front-to-back queue status
  typedef struct packed {
    logic      valid;
    lane_vec_t lanes;
  } queue_head_t;

  typedef struct packed {
    logic [1:0]         dos;
    logic               miss;
    logic [INDEX_W-1:0] idx;
    logic               eol;
    logic               status;
    logic [FREQ_W-1:0]  freq;
  } result_t;

  typedef enum logic {
    ST_RUN,
    ST_DIV
  } back_state_t;

  function automatic lane_t decode_code(input logic [1:0] code, input logic swap);
    lane_t l;
    l.dos  = 2'd0;
    l.miss = 1'b0;
    case (code)
      CODE_HOM_A: l.dos  = swap ? 2'd2 : 2'd0;
      CODE_MISS:  l.miss = 1'b1;
      CODE_HET:   l.dos  = 2'd1;
      CODE_HOM_B: l.dos  = swap ? 2'd0 : 2'd2;
      default:    l.dos  = 2'd0;
    endcase
    return l;
  endfunction

endpackage

[sv/gdu_front.sv]
`timescale 1ns / 1ps
// gdu_front: accepts packed genotype bytes, decodes the four codes into
// dosage lanes and holds them in a two-entry queue. Uses gdu_pkg.
module gdu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          geno_byte,
  input  logic                swap_alleles,
  output gdu_pkg::queue_head_t head,
  input  logic                deq
);

  gdu_pkg::lane_vec_t entries [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  gdu_pkg::lane_vec_t decoded;
  logic               do_push;
  logic               do_pop;

  always_comb begin
    for (int k = 0; k < gdu_pkg::LANES; k++) begin
      decoded[k] = gdu_pkg::decode_code(geno_byte[2*k +: 2], swap_alleles);
    end
  end

  assign full       = (count == 2'd2);
  assign do_push    = push && !full;
  assign do_pop     = deq && (count != 2'd0);
  assign head.valid = (count != 2'd0);
  assign head.lanes = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/gdu_div.sv]
`timescale 1ns / 1ps
// gdu_div: restoring divider, one quotient bit per cycle, for (m << FRAC) / den
// with m < den. Does not use gdu_pkg; self-contained.
module gdu_div #(
  parameter int NW   = 21,
  parameter int FRAC = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NW-1:0]   m,
  input  logic [NW:0]     den,
  output logic            busy,
  output logic [FRAC-1:0] q
);

  localparam int CNT_W = $clog2(FRAC + 1);

  logic [NW:0]      rem;
  logic [NW:0]      den_r;
  logic [CNT_W-1:0] cnt;
  logic [NW+1:0]    shifted;
  logic             ge;

  assign shifted = {rem, 1'b0};
  assign ge      = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {1'b0, m};
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? (NW+1)'(shifted - {1'b0, den_r}) : (NW+1)'(shifted);
      q   <= {q[FRAC-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(FRAC);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end

endmodule

[sv/gdu_back.sv]
`timescale 1ns / 1ps
// gdu_back: walks the decoded lanes one sample per cycle unless stalled by the
// divider or the result register, keeps the locus count, dosage sum and reject
// flag, drives the divider and the result register. Uses gdu_pkg.
module gdu_back #(
  parameter int NW   = 21,
  parameter int FRAC = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [NW-1:0]        n,
  input  logic                 allow_missing,
  input  gdu_pkg::queue_head_t head,
  output logic                 deq,
  output logic                 div_start,
  output logic [NW-1:0]        div_m,
  output logic [NW:0]          div_den,
  input  logic                 div_busy,
  input  logic [FRAC-1:0]      div_q,
  output gdu_pkg::result_t     res,
  output logic                 res_valid,
  input  logic                 res_take
);

  localparam int TW = NW + 1;

  gdu_pkg::back_state_t state, state_next;
  logic [1:0]           lane_idx;
  logic [NW-1:0]        sample_count;
  logic [TW-1:0]        dosage_total;
  logic                 locus_rejected;
  gdu_pkg::result_t     pend;

  gdu_pkg::lane_t   lane;
  logic             last;
  logic [TW-1:0]    total_new;
  logic             rej_new;
  logic             need_emit;
  logic             need_div;
  logic             out_free;
  logic             fire;
  logic             load_res;
  gdu_pkg::result_t res_new;
  gdu_pkg::result_t res_div;
  logic [TW-1:0]    n_ext;
  logic [TW-1:0]    m_clip;
  logic [TW-1:0]    m_fold;

  assign out_free = !res_valid || res_take;
  assign lane     = head.lanes[lane_idx];
  assign last     = ({1'b0, sample_count} + TW'(1)) >= {1'b0, n};
  assign n_ext    = {1'b0, n};
  assign div_den  = {n, 1'b0};

  always_comb begin
    total_new = dosage_total + TW'(lane.dos);
    rej_new   = lane.miss && !allow_missing;
    need_emit = locus_rejected ? last : 1'b1;
    need_div  = !locus_rejected && last && !rej_new;
    m_clip    = (total_new > div_den) ? div_den : total_new;
    m_fold    = (m_clip > n_ext) ? (div_den - m_clip) : m_clip;
    div_m     = NW'(m_fold);

    fire = (state == gdu_pkg::ST_RUN) && head.valid && (need_div || !need_emit || out_free);
    deq       = fire && (last || (lane_idx == 2'd3));
    div_start = fire && need_div;

    res_new.idx    = gdu_pkg::INDEX_W'(sample_count);
    res_new.eol    = last;
    res_new.freq   = '0;
    if (locus_rejected) begin
      res_new.dos    = 2'd0;
      res_new.miss   = 1'b0;
      res_new.status = 1'b1;
    end else begin
      res_new.dos    = lane.dos;
      res_new.miss   = lane.miss;
      res_new.status = rej_new;
    end

    // closing result of an accepted locus, frequency from the divider
    res_div      = pend;
    res_div.freq = gdu_pkg::FREQ_W'(div_q);

    state_next = state;
    load_res   = 1'b0;
    case (state)
      gdu_pkg::ST_RUN: begin
        if (fire && need_div) state_next = gdu_pkg::ST_DIV;
        else if (fire && need_emit) load_res = 1'b1;
      end
      gdu_pkg::ST_DIV: begin
        if (!div_busy && out_free) begin
          state_next = gdu_pkg::ST_RUN;
        end
      end
      default: state_next = gdu_pkg::ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= gdu_pkg::ST_RUN;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (div_start) pend <= res_new;
    if (load_res) begin
      res <= res_new;
    end else if (state == gdu_pkg::ST_DIV && !div_busy && out_free) begin
      res <= res_div;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid      <= 1'b0;
      lane_idx       <= 2'd0;
      sample_count   <= '0;
      dosage_total   <= '0;
      locus_rejected <= 1'b0;
    end else begin
      if (load_res || (state == gdu_pkg::ST_DIV && !div_busy && out_free)) begin
        res_valid <= 1'b1;
      end else if (res_take) begin
        res_valid <= 1'b0;
      end
      if (fire) begin
        lane_idx <= deq ? 2'd0 : lane_idx + 2'd1;
        if (last) begin
          sample_count   <= '0;
          dosage_total   <= '0;
          locus_rejected <= 1'b0;
        end else begin
          sample_count <= sample_count + NW'(1);
          if (!locus_rejected) begin
            dosage_total   <= total_new;
            locus_rejected <= rej_new;
          end
        end
      end
    end
  end

endmodule

[sv/genotype_dosage_unpacker.sv]
`timescale 1ns / 1ps
// genotype_dosage_unpacker: top level with the APB register file; ties the
// front queue, the back sequencer and the divider. Uses gdu_pkg, gdu_front,
// gdu_back, gdu_div.
//
// Usage:
//  - Input queue: drive geno_byte/swap_alleles and raise push while full is
//    low. Each byte carries four 2-bit codes, lowest pair = first sample.
//  - Result queue: while empty is low the oldest result sits on dosage,
//    is_missing, sample_index, end_of_locus, locus_status and minor_freq;
//    pop takes it. Each request yields up to four results, one per sample
//    still inside the locus (after a reject, only the closing one); codes
//    past the last sample are dropped.
//  - Config (APB, byte addr 0: num_samples, 4: allow_missing) is written
//    by the user only while no locus work is pending; the block does not
//    enforce this. pready is tied high.
//  - Throughput: one result per cycle from the back sequencer while the
//    divider is idle and the receiver keeps up. An accepted locus's last
//    sample waits in the restoring divider (one quotient bit per cycle).
//  - Path: queue entry written at the accepting edge, then result register.
//  - The two-entry front queue keeps taking bytes while the back side
//    divides or the receiver stalls; full rises once both entries are held.
//  - Reset (synchronous, rst high) empties both queues, clears the locus
//    count, sum and reject flag, and sets num_samples=1, allow_missing=0.
module genotype_dosage_unpacker #(
  parameter int MAX_SAMPLES    = gdu_pkg::DEF_MAX_SAMPLES,
  parameter int FREQ_FRAC_BITS = gdu_pkg::DEF_FREQ_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // input queue
  input  logic        push,
  output logic        full,
  input  logic [7:0]  geno_byte,
  input  logic        swap_alleles,
  // result queue
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  dosage,
  output logic        is_missing,
  output logic [19:0] sample_index,
  output logic        end_of_locus,
  output logic        locus_status,
  output logic [15:0] minor_freq,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // width of the effective sample count, holds MAX_SAMPLES itself
  localparam int NW = $clog2(MAX_SAMPLES + 1);
  localparam int CW = (NW > gdu_pkg::NUM_SAMPLES_W) ? NW : gdu_pkg::NUM_SAMPLES_W;

  logic [gdu_pkg::NUM_SAMPLES_W-1:0] num_samples;
  logic                              allow_missing;
  logic                              cfg_wr;
  logic [CW-1:0]                     ns_ext;
  logic [NW-1:0]                     n_eff;

  gdu_pkg::queue_head_t head;
  logic                 deq;
  logic                 div_start;
  logic [NW-1:0]        div_m;
  logic [NW:0]          div_den;
  logic                 div_busy;
  logic [FREQ_FRAC_BITS-1:0] div_q;
  gdu_pkg::result_t     res;
  logic                 res_valid;

  // ---- register file ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_samples   <= gdu_pkg::NUM_SAMPLES_W'(1);
      allow_missing <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        gdu_pkg::REG_NUM_SAMPLES:   num_samples   <= pwdata[gdu_pkg::NUM_SAMPLES_W-1:0];
        gdu_pkg::REG_ALLOW_MISSING: allow_missing <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      gdu_pkg::REG_NUM_SAMPLES:   prdata = 32'(num_samples);
      gdu_pkg::REG_ALLOW_MISSING: prdata = 32'(allow_missing);
      default:                    prdata = '0;
    endcase
  end

  // zero counts as one sample, anything above the maximum is clamped
  always_comb begin
    ns_ext = CW'(num_samples);
    if (ns_ext == '0) begin
      n_eff = NW'(1);
    end else if (ns_ext > CW'(MAX_SAMPLES)) begin
      n_eff = NW'(MAX_SAMPLES);
    end else begin
      n_eff = NW'(ns_ext);
    end
  end

  // ---- datapath ----
  gdu_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .geno_byte    (geno_byte),
    .swap_alleles (swap_alleles),
    .head         (head),
    .deq          (deq)
  );

  gdu_back #(
    .NW   (NW),
    .FRAC (FREQ_FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .n             (n_eff),
    .allow_missing (allow_missing),
    .head          (head),
    .deq           (deq),
    .div_start     (div_start),
    .div_m         (div_m),
    .div_den       (div_den),
    .div_busy      (div_busy),
    .div_q         (div_q),
    .res           (res),
    .res_valid     (res_valid),
    .res_take      (pop)
  );

  gdu_div #(
    .NW   (NW),
    .FRAC (FREQ_FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .m     (div_m),
    .den   (div_den),
    .busy  (div_busy),
    .q     (div_q)
  );

  assign empty        = !res_valid;
  assign dosage       = res.dos;
  assign is_missing   = res.miss;
  assign sample_index = res.idx;
  assign end_of_locus = res.eol;
  assign locus_status = res.status;
  assign minor_freq   = res.freq;

endmodule

[sv/gdu_checker.sv]
`timescale 1ns / 1ps
// gdu_checker: port-level assertions for genotype_dosage_unpacker, bound to
// the top level below. No package dependency.
module gdu_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  dosage,
  input logic        is_missing,
  input logic [19:0] sample_index,
  input logic        end_of_locus,
  input logic        locus_status,
  input logic [15:0] minor_freq
);

  // a missing sample never carries a dosage
  a_missing_no_dosage: assert property (@(posedge clk) disable iff (rst)
    !empty && is_missing |-> dosage == 2'd0)
    else $error("missing sample with nonzero dosage");

  // rejected results carry no frequency
  a_reject_no_freq: assert property (@(posedge clk) disable iff (rst)
    !empty && locus_status |-> minor_freq == 16'd0)
    else $error("frequency on rejected result");

  // frequency only on the closing result of a locus
  a_freq_only_at_end: assert property (@(posedge clk) disable iff (rst)
    !empty && !end_of_locus |-> minor_freq == 16'd0)
    else $error("frequency before end of locus");

  // a waiting result holds until taken
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(sample_index) && $stable(dosage)
      && $stable(end_of_locus))
    else $error("waiting result changed");

endmodule

bind genotype_dosage_unpacker gdu_checker u_gdu_checker (
  .clk          (clk),
  .rst          (rst),
  .empty        (empty),
  .pop          (pop),
  .dosage       (dosage),
  .is_missing   (is_missing),
  .sample_index (sample_index),
  .end_of_locus (end_of_locus),
  .locus_status (locus_status),
  .minor_freq   (minor_freq)
);
